// ===== rtl/core/idrq_pkg.sv =====
// ----------------------------------------------------------------------------
// idrq_pkg: shared types and constants for the int8 dot/requant block
// Lane count, stream field layout, register indexes, FSM states, commands.
// ----------------------------------------------------------------------------
`default_nettype none

package idrq_pkg;

    localparam int ROWS   = 4;
    localparam int LANE_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    // input stream layout (tdata), lowest bit first
    localparam int A_W         = 8;
    localparam int BIAS_LSB    = ROWS * A_W + 8;
    localparam int MULT_LSB    = BIAS_LSB + 32;
    localparam int SHIFT_LSB   = MULT_LSB + 32;
    localparam int VALID_LSB   = SHIFT_LSB + 5;
    localparam int IN_BITS     = VALID_LSB + 3;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ROWS * 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_POINT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HIGH = 2'd2;

    localparam logic signed [7:0] ZERO_POINT_RST = 8'sd0;
    localparam logic signed [7:0] CLAMP_LOW_RST  = -8'sd128;
    localparam logic signed [7:0] CLAMP_HIGH_RST = 8'sd127;

    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT32_MAX = 32'sh7fff_ffff;
    localparam logic signed [63:0] HALF_Q31  = 64'sh0000_0000_4000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_MUL,
        ST_HIGH,
        ST_SHIFT,
        ST_OUT,
        ST_LOAD
    } idrq_state_t;

    typedef struct packed {
        logic              acc_en;
        logic              latch_en;
        logic [LANE_W-1:0] lane;
        logic              do_bias;
        logic              do_mul;
        logic              do_high;
        logic              do_shift;
        logic              do_out;
        logic              load_out;
    } idrq_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/idrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// idrq_ctrl: sequencer for accumulation and the per-lane epilogue
// Takes steps while idle, then walks the lanes through bias, multiply,
// rounding, shift and clamp, and loads the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module idrq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    input  wire logic                s_axis_tlast,
    output logic                     s_axis_tready,
    input  wire logic                m_axis_tready,
    output logic                     m_axis_tvalid,
    output idrq_pkg::idrq_cmd_t      cmd
);

    idrq_pkg::idrq_state_t            state_reg, state_next;
    logic [idrq_pkg::LANE_W-1:0]      lane_reg, lane_next;
    logic                             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= idrq_pkg::ST_IDLE;
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        lane_next     = lane_reg;
        cmd           = '0;
        cmd.lane      = lane_reg;
        s_axis_tready = 1'b0;

        unique case (state_reg)
            idrq_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.acc_en   = 1'b1;
                    cmd.latch_en = s_axis_tlast;
                    if (s_axis_tlast)
                    begin
                        lane_next  = '0;
                        state_next = idrq_pkg::ST_BIAS;
                    end
                end
            end
            idrq_pkg::ST_BIAS:
            begin
                cmd.do_bias = 1'b1;
                state_next  = idrq_pkg::ST_MUL;
            end
            idrq_pkg::ST_MUL:
            begin
                cmd.do_mul = 1'b1;
                state_next = idrq_pkg::ST_HIGH;
            end
            idrq_pkg::ST_HIGH:
            begin
                cmd.do_high = 1'b1;
                state_next  = idrq_pkg::ST_SHIFT;
            end
            idrq_pkg::ST_SHIFT:
            begin
                cmd.do_shift = 1'b1;
                state_next   = idrq_pkg::ST_OUT;
            end
            idrq_pkg::ST_OUT:
            begin
                cmd.do_out = 1'b1;
                if (lane_reg == idrq_pkg::LANE_W'(idrq_pkg::ROWS - 1))
                begin
                    state_next = idrq_pkg::ST_LOAD;
                end
                else
                begin
                    lane_next  = lane_reg + 1'b1;
                    state_next = idrq_pkg::ST_BIAS;
                end
            end
            idrq_pkg::ST_LOAD:
            begin
                // wait until the previous result has been taken
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = idrq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = idrq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/idrq_datapath.sv =====
// ----------------------------------------------------------------------------
// idrq_datapath: accumulators, shared requantization unit, output register
// Row MACs run in parallel; the epilogue handles one lane at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module idrq_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire idrq_pkg::idrq_cmd_t                 cmd,
    input  wire logic [idrq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [idrq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [idrq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic      [idrq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int ROWS = idrq_pkg::ROWS;

    logic signed [7:0]  zero_point_reg, clamp_low_reg, clamp_high_reg;
    logic [31:0]        acc_reg [ROWS];
    logic signed [31:0] bias_reg, mult_reg;
    logic [4:0]         shamt_reg;
    logic [2:0]         rows_valid_reg;
    logic signed [31:0] v_reg, high_reg, sh_reg;
    logic signed [63:0] prod_reg;
    logic               sat_reg;
    logic [7:0]         res_reg [ROWS];
    logic [idrq_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic signed [7:0]  b_col;
    logic signed [63:0] prod_next, rnd_sum;
    logic signed [31:0] sh_floor, zp_sum, clamp_lo32, clamp_hi32, lo_sat, res32;
    logic [31:0]        sh_mask, sh_rem, sh_thr;
    logic               lane_ok;

    assign b_col = s_axis_tdata[ROWS*8 +: 8];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_point_reg <= idrq_pkg::ZERO_POINT_RST;
            clamp_low_reg  <= idrq_pkg::CLAMP_LOW_RST;
            clamp_high_reg <= idrq_pkg::CLAMP_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                idrq_pkg::CFG_ZERO_POINT: zero_point_reg <= cfg_wdata;
                idrq_pkg::CFG_CLAMP_LOW:  clamp_low_reg  <= cfg_wdata;
                idrq_pkg::CFG_CLAMP_HIGH: clamp_high_reg <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    // row accumulators, cleared when the result is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (cmd.load_out)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (cmd.acc_en)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                acc_reg[i] <= acc_reg[i]
                    + 32'($signed(s_axis_tdata[i*8 +: 8]) * b_col);
            end
        end
    end

    // per-column parameters, taken with the last step
    always_ff @(posedge clk)
    begin
        if (cmd.latch_en)
        begin
            bias_reg       <= s_axis_tdata[idrq_pkg::BIAS_LSB  +: 32];
            mult_reg       <= s_axis_tdata[idrq_pkg::MULT_LSB  +: 32];
            shamt_reg      <= s_axis_tdata[idrq_pkg::SHIFT_LSB +: 5];
            rows_valid_reg <= s_axis_tdata[idrq_pkg::VALID_LSB +: 3];
        end
    end

    assign prod_next = v_reg * mult_reg;
    assign rnd_sum   = prod_reg + idrq_pkg::HALF_Q31;

    // rounding right shift, ties away from zero
    assign sh_floor = high_reg >>> shamt_reg;
    assign sh_mask  = (32'd1 << shamt_reg) - 32'd1;
    assign sh_rem   = high_reg & sh_mask;
    assign sh_thr   = (sh_mask >> 1) + {31'd0, high_reg[31]};

    // zero point (wrapping) and clamp, low bound first
    assign zp_sum     = sh_reg + 32'(zero_point_reg);
    assign clamp_lo32 = 32'(clamp_low_reg);
    assign clamp_hi32 = 32'(clamp_high_reg);
    assign lo_sat     = (zp_sum < clamp_lo32) ? clamp_lo32 : zp_sum;
    assign res32      = (lo_sat > clamp_hi32) ? clamp_hi32 : lo_sat;
    assign lane_ok    = {1'b0, cmd.lane} < (idrq_pkg::LANE_W + 1)'(rows_valid_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.do_bias)
        begin
            v_reg <= acc_reg[cmd.lane] + bias_reg;
        end
        if (cmd.do_mul)
        begin
            prod_reg <= prod_next;
            sat_reg  <= (v_reg == idrq_pkg::INT32_MIN) && (mult_reg == idrq_pkg::INT32_MIN);
        end
        if (cmd.do_high)
        begin
            high_reg <= sat_reg ? idrq_pkg::INT32_MAX : rnd_sum[62:31];
        end
        if (cmd.do_shift)
        begin
            sh_reg <= sh_floor + ((sh_rem > sh_thr) ? 32'sd1 : 32'sd0);
        end
        if (cmd.do_out)
        begin
            res_reg[cmd.lane] <= lane_ok ? res32[7:0] : 8'd0;
        end
        if (cmd.load_out)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                out_data_reg[i*8 +: 8] <= res_reg[i];
            end
        end
    end

    assign m_axis_tdata = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/int8_dot_requant_four_rows.sv =====
// ----------------------------------------------------------------------------
// int8_dot_requant_four_rows: four-row int8 dot product with requantization
//
//   channel   dir  width  contents
//   s_axis    in   112    one reduction step (tlast = final step)
//   m_axis    out  32     four requantized int8 results
//   cfg       in   8      zero point, clamp low, clamp high
//
// A step that is not last is accumulated while idle. A last step is
// accumulated too; then each lane passes in turn through the shared
// epilogue (bias add, 32x32 multiply, Q31 rounding, rounding shift, zero
// point and clamp), and then the output register is loaded.
// Reset clears accumulators and restores register defaults. A stalled result
// holds the block in its load cycle only if a new column finishes first.
// ----------------------------------------------------------------------------
`default_nettype none

module int8_dot_requant_four_rows (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // a_row0, a_row1, a_row2, a_row3, b_col, channel_bias, channel_multiplier,
    // channel_shift, rows_valid
    input  wire logic [idrq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // out_row0, out_row1, out_row2, out_row3
    output logic      [idrq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [idrq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [idrq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    idrq_pkg::idrq_cmd_t cmd;

    idrq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .cmd           (cmd)
    );

    idrq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .s_axis_tdata (s_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .m_axis_tdata (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // no new request right after a final step: the epilogue owns the block
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("request accepted during epilogue");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten");

    // a result appears only from a load
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.load_out))
        else $error("result valid without load");
`endif

endmodule

`default_nettype wire
